FILE: design/mmc3mc_pkg.sv
// Shared types and constants for the two-game MMC3-style bank mapper.
package mmc3mc_pkg;

  typedef enum logic [1:0] {
    MODE_CPU_WRITE = 2'd0,
    MODE_A12_EDGE  = 2'd1,
    MODE_PRG_XLATE = 2'd2,
    MODE_CHR_XLATE = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CFG_PRG_BANK_MASK = 2'd0,
    CFG_ALT_IRQ_MODE  = 2'd1,
    CFG_FOUR_SCREEN   = 2'd2
  } cfg_index_t;

  localparam logic [15:0] REG_DECODE_MASK  = 16'hE001;
  localparam logic [15:0] REG_BANK_SELECT  = 16'h8000;
  localparam logic [15:0] REG_BANK_DATA    = 16'h8001;
  localparam logic [15:0] REG_MIRRORING    = 16'hA000;
  localparam logic [15:0] REG_RAM_PROTECT  = 16'hA001;
  localparam logic [15:0] REG_IRQ_LATCH    = 16'hC000;
  localparam logic [15:0] REG_IRQ_RELOAD   = 16'hC001;
  localparam logic [15:0] REG_IRQ_DISABLE  = 16'hE000;
  localparam logic [15:0] REG_IRQ_ENABLE   = 16'hE001;

  localparam logic [2:0] CHR_REG_COUNT     = 3'd6;
  localparam logic [7:0] PRG_MASK_RESET    = 8'd31;
  localparam logic [7:0] IRQ_LATCH_RESET   = 8'hFF;
  localparam logic [3:0] PRG_BANK_LOW_MASK = 4'hF;

  // Bank registers that address translation reads.
  typedef struct packed {
    logic [2:0]      bank_select;
    logic            chr_swap;
    logic            prg_swap;
    logic            outer_block;
    logic [5:0][7:0] chr_regs;
    logic [1:0][7:0] prg_regs;
    logic [7:0]      prg_mask;
  } map_state_t;

  // Board status reported with every result.
  typedef struct packed {
    logic mirroring;
    logic ram_enable;
    logic ram_write_ok;
    logic irq_asserted;
  } map_status_t;

endpackage

FILE: design/mmc3mc_regs.sv
// Mapper register file, configuration registers and scanline IRQ counter.
module mmc3mc_regs (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [1:0]               cfg_index,
  input  logic [7:0]               cfg_data,
  input  logic                     step,
  input  mmc3mc_pkg::mode_t        mode,
  input  logic [15:0]              address,
  input  logic [7:0]               data,
  output mmc3mc_pkg::map_state_t   state,
  output mmc3mc_pkg::map_status_t  status_next
);
  import mmc3mc_pkg::*;

  map_state_t  state_next;
  map_status_t status;
  logic        alt_irq_mode;
  logic        four_screen;
  logic [7:0]  irq_count;
  logic [7:0]  irq_count_next;
  logic [7:0]  irq_latch;
  logic [7:0]  irq_latch_next;
  logic        irq_enable;
  logic        irq_enable_next;
  logic        irq_pending;
  logic        irq_pending_next;
  logic        reload;
  logic [7:0]  count_stepped;

  assign reload        = (irq_count == 8'd0) || irq_pending;
  assign count_stepped = reload ? irq_latch : irq_count - 8'd1;

  always_comb begin
    state_next       = state;
    status_next      = status;
    irq_count_next   = irq_count;
    irq_latch_next   = irq_latch;
    irq_enable_next  = irq_enable;
    irq_pending_next = irq_pending;
    if (cfg_write && cfg_index == CFG_PRG_BANK_MASK) begin
      state_next.prg_mask = cfg_data;
    end
    if (step) begin
      unique case (mode)
        MODE_CPU_WRITE: begin
          if (address[15:13] == 3'b011) begin
            if (status.ram_enable && status.ram_write_ok) begin
              state_next.outer_block = data[0];
            end
          end else if (address[15]) begin
            unique case (address & REG_DECODE_MASK)
              REG_BANK_SELECT: begin
                state_next.bank_select = data[2:0];
                state_next.chr_swap    = data[7];
                state_next.prg_swap    = data[6];
              end
              REG_BANK_DATA: begin
                if (state.bank_select < CHR_REG_COUNT) begin
                  state_next.chr_regs[state.bank_select] = data;
                end else begin
                  state_next.prg_regs[state.bank_select[0]] = data & state.prg_mask;
                end
              end
              REG_MIRRORING: begin
                if (!four_screen) begin
                  status_next.mirroring = data[0];
                end
              end
              REG_RAM_PROTECT: begin
                status_next.ram_enable   = data[7];
                status_next.ram_write_ok = ~data[6];
              end
              REG_IRQ_LATCH: begin
                irq_latch_next = data;
              end
              REG_IRQ_RELOAD: begin
                irq_count_next = 8'd0;
                if (alt_irq_mode) begin
                  irq_pending_next = 1'b1;
                end
              end
              REG_IRQ_DISABLE: begin
                irq_enable_next          = 1'b0;
                status_next.irq_asserted = 1'b0;
              end
              default: begin
                irq_enable_next = 1'b1;
              end
            endcase
          end
        end
        MODE_A12_EDGE: begin
          irq_count_next   = count_stepped;
          irq_pending_next = 1'b0;
          // Alternate mode: a reload to zero fires only from a live count or a clear.
          if ((!alt_irq_mode || irq_count != 8'd0 || irq_pending) &&
              count_stepped == 8'd0 && irq_enable) begin
            status_next.irq_asserted = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.bank_select <= '0;
      state.chr_swap    <= 1'b0;
      state.prg_swap    <= 1'b0;
      state.outer_block <= 1'b0;
      state.chr_regs    <= '0;
      state.prg_regs[0] <= 8'd0;
      state.prg_regs[1] <= 8'd1;
      state.prg_mask    <= PRG_MASK_RESET;
      status            <= '0;
      alt_irq_mode      <= 1'b0;
      four_screen       <= 1'b0;
      irq_count         <= 8'd0;
      irq_latch         <= IRQ_LATCH_RESET;
      irq_enable        <= 1'b0;
      irq_pending       <= 1'b0;
    end else begin
      state       <= state_next;
      status      <= status_next;
      irq_count   <= irq_count_next;
      irq_latch   <= irq_latch_next;
      irq_enable  <= irq_enable_next;
      irq_pending <= irq_pending_next;
      if (cfg_write && cfg_index == CFG_ALT_IRQ_MODE) begin
        alt_irq_mode <= cfg_data[0];
      end
      if (cfg_write && cfg_index == CFG_FOUR_SCREEN) begin
        four_screen <= cfg_data[0];
      end
    end
  end

endmodule

FILE: design/mmc3mc_xlate.sv
// PRG and CHR address translation from the current bank registers.
module mmc3mc_xlate (
  input  mmc3mc_pkg::mode_t       mode,
  input  logic [15:0]             address,
  input  mmc3mc_pkg::map_state_t  state,
  output logic [7:0]              bank
);
  import mmc3mc_pkg::*;

  logic [1:0] prg_slot;
  logic [7:0] prg_reg;
  logic [7:0] prg_bank;
  logic [2:0] chr_slot;
  logic [2:0] chr_index;
  logic [7:0] chr_reg;
  logic [7:0] chr_bank;

  always_comb begin
    prg_slot = address[14:13];
    case (prg_slot)
      2'd1:    prg_reg = state.prg_regs[1];
      2'd3:    prg_reg = state.prg_mask;
      default: begin
        if ((prg_slot == 2'd0) != state.prg_swap) begin
          prg_reg = state.prg_regs[0];
        end else begin
          prg_reg = state.prg_mask - 8'd1;
        end
      end
    endcase
    prg_bank = address[15] ? {3'b000, state.outer_block, prg_reg[3:0] & PRG_BANK_LOW_MASK}
                           : 8'd0;
  end

  always_comb begin
    chr_slot  = address[12:10] ^ {state.chr_swap, 2'b00};
    chr_index = chr_slot[2] ? {1'b0, chr_slot[1:0]} + 3'd2 : {2'b00, chr_slot[1]};
    chr_reg   = state.chr_regs[chr_index];
    // Low half uses 2K pairs: the bottom bit comes from the slot.
    if (chr_slot[2]) begin
      chr_bank = {state.outer_block, chr_reg[6:0]};
    end else begin
      chr_bank = {state.outer_block, chr_reg[6:1], chr_slot[0]};
    end
  end

  always_comb begin
    unique case (mode)
      MODE_PRG_XLATE: bank = prg_bank;
      MODE_CHR_XLATE: bank = chr_bank;
      default:        bank = 8'd0;
    endcase
  end

endmodule

FILE: design/mmc3_multicart_bank_mapper.sv
// Throughput 1 beat a cycle while the result channel is not stalled.
// Each beat is registered in the input stage, worked through the register file and translator,
// and its result lands in the output register as the mapper state updates.
// Synchronous active-high reset clears both valid flags, resets the bank registers and the
// IRQ counter, and returns the configuration registers to their defaults.
module mmc3_multicart_bank_mapper (
  input  logic        clk,
  input  logic        rst,
  // Configuration write port
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  // Bus event channel
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [1:0]  mode,
  input  logic [15:0] address,
  input  logic [7:0]  data,
  // Result channel
  output logic        result_valid,
  input  logic        result_stall,
  output logic [7:0]  bank,
  output logic        mirror_horizontal,
  output logic        ram_enabled,
  output logic        ram_writable,
  output logic        irq_line
);
  import mmc3mc_pkg::*;

  // Input register stage
  logic        hold_valid;
  mode_t       hold_mode;
  logic [15:0] hold_address;
  logic [7:0]  hold_data;

  logic        advance;
  logic        take_item;
  map_state_t  state;
  map_status_t status_next;
  logic [7:0]  bank_next;

  // Advance the held beat whenever the result register is empty or draining.
  assign advance    = hold_valid && (!result_valid || !result_stall);
  assign item_stall = hold_valid && !advance;
  assign take_item  = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (take_item) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_item) begin
      hold_mode    <= mode_t'(mode);
      hold_address <= address;
      hold_data    <= data;
    end
  end

  // State updates on the same edge that the result is captured, so the next
  // held beat always sees every earlier write and A12 edge.
  mmc3mc_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .step        (advance),
    .mode        (hold_mode),
    .address     (hold_address),
    .data        (hold_data),
    .state       (state),
    .status_next (status_next)
  );

  // Translation reads the current registers; translating beats change none.
  mmc3mc_xlate u_xlate (
    .mode    (hold_mode),
    .address (hold_address),
    .state   (state),
    .bank    (bank_next)
  );

  // Result register: hold while stalled, drop valid once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      bank              <= bank_next;
      mirror_horizontal <= status_next.mirroring;
      ram_enabled       <= status_next.ram_enable;
      ram_writable      <= status_next.ram_write_ok;
      irq_line          <= status_next.irq_asserted;
    end
  end

endmodule

FILE: verif/mmc3_multicart_bank_mapper_test.sv
// Self-checking testbench for the two-game MMC3-style bank mapper.
`timescale 1ns / 100ps

module mmc3_multicart_bank_mapper_test;
  import mmc3mc_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 64;
  localparam int PHASE_ITEMS   = 160;

  // One bus event as it is offered on the input channel.
  typedef struct packed {
    mode_t       op;
    logic [15:0] addr;
    logic [7:0]  wdata;
  } bus_event_t;

  // What the mapper is expected to report for one bus event.
  typedef struct packed {
    logic [7:0]  bank;
    map_status_t status;
  } mapper_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = CFG_PRG_BANK_MASK;
  logic [7:0]  cfg_data = '0;
  logic        item_valid = 1'b0;
  logic        item_stall;
  logic [1:0]  mode = MODE_CPU_WRITE;
  logic [15:0] address = '0;
  logic [7:0]  data = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [7:0]  bank;
  logic        mirror_horizontal;
  logic        ram_enabled;
  logic        ram_writable;
  logic        irq_line;

  mmc3_multicart_bank_mapper dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .mode(mode),
    .address(address),
    .data(data),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .bank(bank),
    .mirror_horizontal(mirror_horizontal),
    .ram_enabled(ram_enabled),
    .ram_writable(ram_writable),
    .irq_line(irq_line)
  );

  // Mapper shadow: bank registers, board status, scanline counter, configuration.
  map_state_t  banks;
  map_status_t board;
  logic [7:0]  irq_count;
  logic [7:0]  irq_latch;
  logic        irq_enable;
  logic        irq_reload_pending;
  logic        alt_irq;
  logic        four_screen_fixed;

  bus_event_t     pending_events[$];
  mapper_result_t expected_results[$];
  bus_event_t     on_bus;
  mapper_result_t seen_exp;

  int items_queued = 0;
  int results_seen = 0;
  int fail_count   = 0;
  int cycle_count  = 0;

  // Sender burst shaping.
  int burst_left = 0;
  int idle_left  = 0;

  // Receiver stall shaping.
  int stall_pct  = 0;
  int style_left = 0;
  int hold_left  = 0;
  bit hold_done  = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Advance the shadow mapper by one bus event and return what it reports.
  function automatic mapper_result_t model_bus_event(bus_event_t ev);
    mapper_result_t res;
    logic [7:0]     prev_count;
    logic [7:0]     sel_reg;
    logic [1:0]     prg_slot;
    logic [2:0]     chr_slot;
    res.bank = 8'd0;
    case (ev.op)
      MODE_CPU_WRITE: begin
        if (ev.addr >= 16'h6000 && ev.addr < 16'h8000) begin
          // outer block only sticks while PRG RAM is on and writable
          if (board.ram_enable && board.ram_write_ok)
            banks.outer_block = ev.wdata[0];
        end else if (ev.addr >= 16'h8000) begin
          case (ev.addr & REG_DECODE_MASK)
            REG_BANK_SELECT: begin
              banks.bank_select = ev.wdata[2:0];
              banks.chr_swap    = ev.wdata[7];
              banks.prg_swap    = ev.wdata[6];
            end
            REG_BANK_DATA: begin
              if (banks.bank_select < CHR_REG_COUNT)
                banks.chr_regs[banks.bank_select] = ev.wdata;
              else
                banks.prg_regs[banks.bank_select[0]] = ev.wdata & banks.prg_mask;
            end
            REG_MIRRORING: begin
              if (!four_screen_fixed)
                board.mirroring = ev.wdata[0];
            end
            REG_RAM_PROTECT: begin
              board.ram_enable   = ev.wdata[7];
              board.ram_write_ok = ~ev.wdata[6];
            end
            REG_IRQ_LATCH: irq_latch = ev.wdata;
            REG_IRQ_RELOAD: begin
              if (alt_irq)
                irq_reload_pending = 1'b1;
              irq_count = 8'd0;
            end
            REG_IRQ_DISABLE: begin
              irq_enable         = 1'b0;
              board.irq_asserted = 1'b0;
            end
            default: irq_enable = 1'b1;
          endcase
        end
      end
      MODE_A12_EDGE: begin
        prev_count = irq_count;
        if (irq_count == 8'd0 || irq_reload_pending)
          irq_count = irq_latch;
        else
          irq_count = irq_count - 8'd1;
        // alternate mode: a reload to zero fires only after a nonzero count or a clear
        if ((!alt_irq || prev_count != 8'd0 || irq_reload_pending) &&
            irq_count == 8'd0 && irq_enable)
          board.irq_asserted = 1'b1;
        irq_reload_pending = 1'b0;
      end
      MODE_PRG_XLATE: begin
        if (ev.addr >= 16'h8000) begin
          prg_slot = ev.addr[14:13];
          if (prg_slot == 2'd1)
            sel_reg = banks.prg_regs[1];
          else if (prg_slot == 2'd3)
            sel_reg = banks.prg_mask;
          else if ((prg_slot == 2'd0) != banks.prg_swap)
            sel_reg = banks.prg_regs[0];
          else
            sel_reg = banks.prg_mask - 8'd1;
          res.bank = {3'b000, banks.outer_block, sel_reg[3:0] & PRG_BANK_LOW_MASK};
        end
      end
      default: begin
        // only A12..A10 pick the 1K slot; upper address bits are don't-care
        chr_slot = ev.addr[12:10] ^ {banks.chr_swap, 2'b00};
        if (chr_slot < 3'd4) begin
          sel_reg  = banks.chr_regs[chr_slot >> 1];
          res.bank = {banks.outer_block, sel_reg[6:1], chr_slot[0]};
        end else begin
          sel_reg  = banks.chr_regs[chr_slot - 3'd2];
          res.bank = {banks.outer_block, sel_reg[6:0]};
        end
      end
    endcase
    res.status = board;
    return res;
  endfunction

  // Driver: hold the beat until it is taken, then offer the next after any gap.
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall)
        expected_results.push_back(model_bus_event(on_bus));
      if (!item_valid || !item_stall) begin
        if (idle_left > 0) begin
          idle_left--;
          item_valid <= 1'b0;
        end else if (pending_events.size() > 0) begin
          on_bus = pending_events.pop_front();
          item_valid <= 1'b1;
          mode       <= on_bus.op;
          address    <= on_bus.addr;
          data       <= on_bus.wdata;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            idle_left  = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall on a changing duty, plus one long hold-off to back the mapper up.
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else if (!hold_done && item_valid && results_seen >= 300) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      result_stall <= 1'b1;
    end else begin
      if (style_left == 0) begin
        case ($urandom_range(0, 4))
          0, 1:    stall_pct = 0;
          2:       stall_pct = 20;
          3:       stall_pct = 50;
          default: stall_pct = 80;
        endcase
        style_left = $urandom_range(20, 150);
      end else begin
        style_left--;
      end
      result_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  function automatic void check_field(string name, int exp_val, int got_val);
    if (exp_val != got_val) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_val, got_val);
      fail_count++;
    end
  endfunction

  // Monitor: compare every beat taken on the result channel with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result beat: bank %0d", bank);
        fail_count++;
      end else begin
        seen_exp = expected_results.pop_front();
        check_field("bank", seen_exp.bank, bank);
        check_field("mirror_horizontal", seen_exp.status.mirroring, mirror_horizontal);
        check_field("ram_enabled", seen_exp.status.ram_enable, ram_enabled);
        check_field("ram_writable", seen_exp.status.ram_write_ok, ram_writable);
        check_field("irq_line", seen_exp.status.irq_asserted, irq_line);
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic add_event(mode_t op, logic [15:0] a, logic [7:0] d);
    bus_event_t ev;
    ev.op    = op;
    ev.addr  = a;
    ev.wdata = d;
    pending_events.push_back(ev);
    items_queued++;
  endtask

  // Register address, sometimes with the undecoded bits scrambled.
  function automatic logic [15:0] reg_alias(logic [15:0] base);
    logic [15:0] noise;
    noise = $urandom;
    return $urandom_range(0, 1) ? (base | (noise & ~REG_DECODE_MASK)) : base;
  endfunction

  task automatic add_translate();
    add_event($urandom_range(0, 1) ? MODE_PRG_XLATE : MODE_CHR_XLATE,
              $urandom_range(0, 16'hFFFF), $urandom_range(0, 255));
  endtask

  task automatic write_cfg(cfg_index_t idx, logic [7:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      CFG_PRG_BANK_MASK: banks.prg_mask = val;
      CFG_ALT_IRQ_MODE:  alt_irq = val[0];
      default:           four_screen_fixed = val[0];
    endcase
  endtask

  task automatic wait_for_results();
    while (results_seen < items_queued)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly well-formed programming sequences with random content, some raw noise.
  task automatic add_random_phase(int count);
    int start_cnt;
    int n;
    start_cnt = items_queued;
    while (items_queued - start_cnt < count) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          add_event(MODE_CPU_WRITE, reg_alias(REG_BANK_SELECT), $urandom_range(0, 255));
          add_event(MODE_CPU_WRITE, reg_alias(REG_BANK_DATA), $urandom_range(0, 255));
          add_translate();
        end
        2, 3: begin
          add_event(MODE_CPU_WRITE, reg_alias(REG_IRQ_LATCH),
                    $urandom_range(0, 1) ? $urandom_range(0, 4) : $urandom_range(0, 255));
          if ($urandom_range(0, 9) < 7)
            add_event(MODE_CPU_WRITE, reg_alias(REG_IRQ_RELOAD), $urandom_range(0, 255));
          if ($urandom_range(0, 9) < 8)
            add_event(MODE_CPU_WRITE, reg_alias(REG_IRQ_ENABLE), $urandom_range(0, 255));
          n = $urandom_range(1, 12);
          repeat (n) begin
            add_event(MODE_A12_EDGE, $urandom_range(0, 16'hFFFF), $urandom_range(0, 255));
            if ($urandom_range(0, 3) == 0)
              add_translate();
          end
          if ($urandom_range(0, 9) < 4)
            add_event(MODE_CPU_WRITE, reg_alias(REG_IRQ_DISABLE), $urandom_range(0, 255));
        end
        4: begin
          add_event(MODE_CPU_WRITE, reg_alias(REG_RAM_PROTECT), $urandom_range(0, 255));
          add_event(MODE_CPU_WRITE, $urandom_range(16'h6000, 16'h7FFF),
                    $urandom_range(0, 255));
          add_translate();
        end
        5:
          add_event(MODE_CPU_WRITE, reg_alias(REG_MIRRORING), $urandom_range(0, 255));
        6, 7, 8: begin
          n = $urandom_range(2, 6);
          repeat (n) add_translate();
        end
        default:
          add_event(mode_t'($urandom_range(0, 3)), $urandom_range(0, 16'hFFFF),
                    $urandom_range(0, 255));
      endcase
    end
  endtask

  initial begin
    // reset state of the shadow mapper
    banks.bank_select  = 3'd0;
    banks.chr_swap     = 1'b0;
    banks.prg_swap     = 1'b0;
    banks.outer_block  = 1'b0;
    banks.chr_regs     = '0;
    banks.prg_regs[0]  = 8'd0;
    banks.prg_regs[1]  = 8'd1;
    banks.prg_mask     = PRG_MASK_RESET;
    board              = '0;
    irq_count          = 8'd0;
    irq_latch          = IRQ_LATCH_RESET;
    irq_enable         = 1'b0;
    irq_reload_pending = 1'b0;
    alt_irq            = 1'b0;
    four_screen_fixed  = 1'b0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed beats under the reset configuration.
    add_event(MODE_PRG_XLATE, 16'h0000, 8'h00);   // below $8000: bank 0
    add_event(MODE_PRG_XLATE, 16'hFFFF, 8'hFF);   // last fixed bank
    add_event(MODE_PRG_XLATE, 16'hC000, 8'h00);   // second-last fixed bank
    add_event(MODE_CHR_XLATE, 16'hFFFF, 8'h00);   // high PPU bits ignored
    add_event(MODE_CPU_WRITE, 16'h5FFF, 8'hFF);   // below $6000: dropped
    add_event(MODE_CPU_WRITE, 16'h6000, 8'h01);   // outer block while RAM off: dropped
    add_event(MODE_CPU_WRITE, REG_RAM_PROTECT, 8'h80);
    add_event(MODE_CPU_WRITE, 16'h7FFF, 8'hFF);   // outer block now taken
    add_event(MODE_CPU_WRITE, REG_BANK_SELECT, 8'hC6);
    add_event(MODE_CPU_WRITE, REG_BANK_DATA, 8'hFF);
    add_event(MODE_PRG_XLATE, 16'h8000, 8'h00);   // swapped PRG layout
    add_event(MODE_PRG_XLATE, 16'hC000, 8'h00);
    add_event(MODE_CHR_XLATE, 16'h0400, 8'h00);   // swapped CHR layout
    add_event(MODE_CPU_WRITE, 16'h9FFE, 8'h00);   // aliased bank select
    add_event(MODE_CPU_WRITE, REG_BANK_DATA, 8'hFF);
    add_event(MODE_CHR_XLATE, 16'h0400, 8'h00);   // 2K pair low bit from slot
    add_event(MODE_CPU_WRITE, REG_MIRRORING, 8'h01);
    add_event(MODE_CPU_WRITE, REG_IRQ_LATCH, 8'h00);
    add_event(MODE_CPU_WRITE, REG_IRQ_RELOAD, 8'h00);
    add_event(MODE_CPU_WRITE, REG_IRQ_ENABLE, 8'h00);
    add_event(MODE_A12_EDGE, 16'h1000, 8'h00);    // reload to zero raises IRQ
    add_event(MODE_CPU_WRITE, REG_IRQ_DISABLE, 8'h00);
    add_event(MODE_CPU_WRITE, REG_RAM_PROTECT, 8'h40);
    add_event(MODE_CPU_WRITE, 16'h6000, 8'h00);   // RAM off again: dropped
    add_event(MODE_PRG_XLATE, 16'hA000, 8'h00);
    wait_for_results();

    // Random phases, each under its own configuration, extremes first.
    for (int p = 0; p < 5; p++) begin
      write_cfg(CFG_PRG_BANK_MASK, (p == 0) ? 8'd255 : (p == 1) ? 8'd1 : $urandom_range(1, 255));
      write_cfg(CFG_ALT_IRQ_MODE, (p == 0) ? 8'd0 : (p == 1) ? 8'd1 : $urandom_range(0, 1));
      write_cfg(CFG_FOUR_SCREEN, (p == 0) ? 8'd0 : (p == 1) ? 8'd1 : $urandom_range(0, 1));
      add_random_phase(PHASE_ITEMS);
      wait_for_results();
    end

    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      fail_count++;
    end
    if (fail_count == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

FILE: files.f
design/mmc3mc_pkg.sv
design/mmc3mc_regs.sv
design/mmc3mc_xlate.sv
design/mmc3_multicart_bank_mapper.sv
verif/mmc3_multicart_bank_mapper_test.sv
